/* hw/rtl/bse_pkg.sv */
// ----------------------------------------------------------------------------
// bse_pkg - shared definitions for the bitmap sort engine
// Request codes, controller states and default store size.
// ----------------------------------------------------------------------------
package bse_pkg;

	// default store size in bytes (eight values per byte)
	localparam int STORE_BYTES_DEF = 8192;

	// width of the returned value field
	localparam int OUT_W = 16;

	// request codes carried on the input tuser
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_FETCH  = 2'd1;
	localparam logic [1:0] REQ_REWIND = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_WR,
		ST_F_CHK,
		ST_RESULT
	} state_t;

endpackage

/* hw/rtl/bitmap_sort_engine.sv */
// ----------------------------------------------------------------------------
// bitmap_sort_engine - bitmap sort over a byte-wide bit store
// Insert sets one bit by read-modify-write; fetch scans upward from a cursor
// one byte per cycle and returns the next set value; rewind resets the cursor.
// ----------------------------------------------------------------------------
// Path: in-range insert via INS_WR, in-range fetch via F_CHK, else direct
//   to RESULT, which loads the result register once the output is free.
// Throughput: one item at a time; a new transfer in the cycle after the result
//   register loads; the fetch scan reads one store byte per cycle.
// Reset: cursor cleared at once; a clearing pass then writes STORE_BYTES
//   zero bytes, one per cycle, while no input is accepted.
module bitmap_sort_engine #(
	parameter int STORE_BYTES = bse_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] out_value
	output logic [1:0]  m_axis_tuser    // [0] found, [1] rejected
);

	localparam int STORE_BITS = STORE_BYTES * 8;
	localparam int ADDR_W     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CUR_W      = $clog2(STORE_BITS + 1);
	localparam int BI_W       = CUR_W - 3;

	// lowest set bit of a byte
	function automatic logic [2:0] low_bit(input logic [7:0] b);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	bse_pkg::state_t state_q, state_d;

	logic [7:0]          mem [STORE_BYTES];
	logic [7:0]          rd_data_q;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;
	logic                mem_we;

	logic [ADDR_W-1:0]   clr_q;
	logic [CUR_W-1:0]    cursor_q;
	logic [BI_W-1:0]     bi_q;
	logic                first_q;
	logic [ADDR_W-1:0]   ins_addr_q;
	logic [2:0]          ins_bit_q;
	logic [15:0]         res_value_q;
	logic                res_found_q;
	logic                res_rej_q;

	logic                m_tvalid_q;
	logic [15:0]         m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic                in_xfer;
	logic                out_free;
	logic                ins_over;
	logic                cur_end;
	logic [7:0]          scan_byte;
	logic                scan_hit;
	logic [2:0]          hit_bit;
	logic [BI_W-1:0]     bi_nxt;
	logic [CUR_W-1:0]    hit_pos;

	assign s_axis_tready = (state_q == bse_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign ins_over      = {1'b0, s_axis_tdata[30:0]} >= 32'(STORE_BITS);
	assign cur_end       = cursor_q >= CUR_W'(STORE_BITS);

	// mask bits below the cursor on the first byte of a scan
	assign scan_byte = first_q ? (rd_data_q & (8'hFF << cursor_q[2:0])) : rd_data_q;
	assign scan_hit  = scan_byte != 8'd0;
	assign hit_bit   = low_bit(scan_byte);
	assign bi_nxt    = bi_q + BI_W'(1);
	assign hit_pos   = {bi_q, hit_bit};

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	// next state and store access
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = ins_addr_q;
		mem_wdata = rd_data_q | (8'd1 << ins_bit_q);
		mem_raddr = cursor_q[ADDR_W+2:3];
		case (state_q)
			bse_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'd0;
				if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
					state_d = bse_pkg::ST_IDLE;
				end
			end
			bse_pkg::ST_IDLE: begin
				if (s_axis_tuser == bse_pkg::REQ_INSERT) begin
					mem_raddr = s_axis_tdata[ADDR_W+2:3];
				end
				if (in_xfer) begin
					case (s_axis_tuser)
						bse_pkg::REQ_INSERT: begin
							state_d = ins_over ? bse_pkg::ST_RESULT : bse_pkg::ST_INS_WR;
						end
						bse_pkg::REQ_FETCH: begin
							state_d = cur_end ? bse_pkg::ST_RESULT : bse_pkg::ST_F_CHK;
						end
						default: begin
							state_d = bse_pkg::ST_RESULT;
						end
					endcase
				end
			end
			bse_pkg::ST_INS_WR: begin
				mem_we  = 1'b1;
				state_d = bse_pkg::ST_RESULT;
			end
			bse_pkg::ST_F_CHK: begin
				mem_raddr = bi_nxt[ADDR_W-1:0];
				if (scan_hit || bi_nxt == BI_W'(STORE_BYTES)) begin
					state_d = bse_pkg::ST_RESULT;
				end
			end
			bse_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = bse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bse_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bse_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clear sweep counter and scan cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			cursor_q <= '0;
		end else begin
			if (state_q == bse_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (in_xfer && s_axis_tuser == bse_pkg::REQ_REWIND) begin
				cursor_q <= '0;
			end else if (state_q == bse_pkg::ST_F_CHK) begin
				if (scan_hit) begin
					cursor_q <= hit_pos + CUR_W'(1);
				end else if (bi_nxt == BI_W'(STORE_BYTES)) begin
					cursor_q <= CUR_W'(STORE_BITS);
				end
			end
		end
	end

	// request payload and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			bse_pkg::ST_IDLE: begin
				ins_addr_q  <= s_axis_tdata[ADDR_W+2:3];
				ins_bit_q   <= s_axis_tdata[2:0];
				bi_q        <= cursor_q[CUR_W-1:3];
				first_q     <= 1'b1;
				res_value_q <= '0;
				res_found_q <= 1'b0;
				res_rej_q   <= (s_axis_tuser == bse_pkg::REQ_INSERT) && ins_over;
			end
			bse_pkg::ST_F_CHK: begin
				bi_q    <= bi_nxt;
				first_q <= 1'b0;
				if (scan_hit) begin
					res_value_q <= 16'(32'(hit_pos));
					res_found_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: hold until the downstream transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == bse_pkg::ST_RESULT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bse_pkg::ST_RESULT && out_free) begin
			m_tdata_q <= res_value_q;
			m_tuser_q <= {res_rej_q, res_found_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule
